/* rtl/rv32ie_pkg.sv */
// Shared types and constants for the RV32I instruction executor.
// Used by rv32i_instruction_executor; no dependencies.
package rv32ie_pkg;

   // request kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_STEP  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // response status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_ECALL   = 2'd1;
   localparam logic [1:0] STS_HALT    = 2'd2;
   localparam logic [1:0] STS_ILLEGAL = 2'd3;

   // major opcodes
   localparam logic [6:0] OP_REG    = 7'b0110011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_IMM    = 7'b0010011;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_SYSTEM = 7'b1110011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] OP_JAL    = 7'b1101111;

   // funct3 codes
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_B  = 3'd0;
   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_BU = 3'd4;
   localparam logic [2:0] F3_HU = 3'd5;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_PRIV = 3'd0;

   // environment call registers and exit services
   localparam logic [4:0]  REG_A0    = 5'd10;
   localparam logic [4:0]  REG_A7    = 5'd17;
   localparam logic [31:0] SVC_EXIT  = 32'd10;
   localparam logic [31:0] SVC_EXIT2 = 32'd93;

   // byte count minus one of a memory access
   localparam logic [1:0] LAST_BYTE = 2'd0;
   localparam logic [1:0] LAST_HALF = 2'd1;
   localparam logic [1:0] LAST_WORD = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] load_address;
      logic [31:0] load_data;
      logic [4:0]  query_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] fetch_pc;
      logic [31:0] fetched_word;
      logic        dest_written;
      logic [4:0]  dest_number;
      logic [31:0] dest_value;
      logic [31:0] service_number;
      logic [31:0] service_argument;
      logic [31:0] query_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUERY,
      ST_DECODE,
      ST_EXEC,
      ST_LOAD,
      ST_DONE
   } state_type;

   function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                       input logic [31:0] a, input logic [31:0] b);
      logic [4:0]  s;
      logic [31:0] q;
      s = b[4:0];
      case (f3)
         F3_ADD:  q = alt ? a - b : a + b;
         F3_SLL:  q = a << s;
         F3_SLT:  q = {31'd0, $signed(a) < $signed(b)};
         F3_SLTU: q = {31'd0, a < b};
         F3_XOR:  q = a ^ b;
         F3_SR:   q = alt ? 32'($signed(a) >>> s) : a >> s;
         F3_OR:   q = a | b;
         default: q = a & b;
      endcase
      return q;
   endfunction

   function automatic logic take_branch(input logic [2:0] f3,
                                        input logic [31:0] a, input logic [31:0] b);
      logic t;
      case (f3)
         F3_BEQ:  t = (a == b);
         F3_BNE:  t = (a != b);
         F3_BLT:  t = $signed(a) < $signed(b);
         F3_BGE:  t = !($signed(a) < $signed(b));
         F3_BLTU: t = a < b;
         F3_BGEU: t = a >= b;
         default: t = 1'b0;
      endcase
      return t;
   endfunction

endpackage

/* rtl/rv32ie_ram.sv */
// Generic one-write, one-read RAM with a registered read port.
// No dependencies.
module rv32ie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rv32i_instruction_executor.sv */
// RV32I multicycle core with a byte memory held in four lane RAMs.
// Depends on rv32ie_pkg and rv32ie_ram.
//
// Requests arrive on req_valid/req_ready with req_data, responses leave on
// rsp_valid/rsp_ready with rsp_data; every request except kind 3 yields one
// response. Kind 0 writes a program word, kind 1 executes one instruction at
// the program counter, kind 2 reads a general register.
// A request runs through states to ST_DONE, which registers the response: a
// program write goes there directly, a register read via ST_QUERY, a step
// via ST_DECODE and ST_EXEC (ST_LOAD too for loads), a halted step directly.
// Fetch, register and load reads come from registered RAMs; one request at a time.
// MEM_BYTES must be a power of two; the memory is split into four byte lanes
// of MEM_BYTES/4 rows so a word at any byte address reads or writes in a single
// access of all four lanes, with each byte wrapping at the end of memory.
// After reset the block sweeps the memory to zero, one row per cycle, through
// all MEM_BYTES/4 rows with req_ready low. Registers reset to zero through
// per-entry valid bits; the program counter and halt flag clear at once.
// The response sits in an output register; a stalled receiver holds it while
// the next request is accepted and worked, which then waits in its last state.
module rv32i_instruction_executor #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rv32ie_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rv32ie_pkg::rsp_type rsp_data
);
   import rv32ie_pkg::*;

   localparam int AW   = $clog2(MEM_BYTES);
   localparam int RAW  = AW - 2;
   localparam int ROWS = MEM_BYTES / 4;

   // state and response registers
   state_type   state_ff, state_in;
   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;
   logic [31:0] ins_ff, ins_in;
   logic [1:0]  rd_off_ff, rd_off_in;
   logic [RAW-1:0] clr_ff, clr_in;
   logic [31:0] vld_ff, vld_in;
   logic [4:0]  idx_a_ff, idx_b_ff;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // memory access request
   logic [AW-1:0] mem_addr;
   logic          mem_wr;
   logic [1:0]    mem_last;
   logic [31:0]   mem_wdata;
   logic [31:0]   mem_word;
   logic [31:0]   load_val;

   logic          ln_we    [4];
   logic [RAW-1:0] ln_waddr [4];
   logic [7:0]    ln_wdata [4];
   logic [RAW-1:0] ln_raddr [4];
   logic [7:0]    ln_rdata [4];

   // register file: two copies for two read ports
   logic [4:0]  rf_raddr_a, rf_raddr_b, rf_waddr;
   logic        rf_we;
   logic [31:0] rf_wdata, rfa_q, rfb_q, rfa_val, rfb_val;

   // decode of the held instruction
   logic [6:0]  ex_op;
   logic [2:0]  ex_f3;
   logic [4:0]  ex_rd;
   logic [31:0] immi, imms, immb, immj, immu;
   logic [31:0] alu_b, alu_q, ld_addr, st_addr, jmp_tgt, pc_plus4;
   logic        alu_alt, ex_take, ex_jump;

   // byte lanes: lane g holds bytes whose address is g modulo 4
   for (genvar g = 0; g < 4; g++) begin : g_lane
      logic [1:0]     bsel;
      logic [RAW-1:0] row;
      assign bsel = 2'(g) - mem_addr[1:0];
      assign row  = mem_addr[AW-1:2] + RAW'(2'(g) < mem_addr[1:0]);
      assign ln_we[g]    = (state_ff == ST_CLEAR) || (mem_wr && (bsel <= mem_last));
      assign ln_waddr[g] = (state_ff == ST_CLEAR) ? clr_ff : row;
      assign ln_wdata[g] = (state_ff == ST_CLEAR) ? 8'd0 : mem_wdata[8*bsel +: 8];
      assign ln_raddr[g] = row;

      rv32ie_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
         .clock   (clock),
         .wr_en   (ln_we[g]),
         .wr_addr (ln_waddr[g]),
         .wr_data (ln_wdata[g]),
         .rd_addr (ln_raddr[g]),
         .rd_data (ln_rdata[g])
      );
   end

   rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (rf_raddr_a),
      .rd_data (rfa_q)
   );

   rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (rf_raddr_b),
      .rd_data (rfb_q)
   );

   // x0 and never-written registers read as zero
   assign rfa_val = (idx_a_ff == 5'd0 || !vld_ff[idx_a_ff]) ? 32'd0 : rfa_q;
   assign rfb_val = (idx_b_ff == 5'd0 || !vld_ff[idx_b_ff]) ? 32'd0 : rfb_q;

   // reassemble the little-endian word from the lanes
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mem_word[8*i +: 8] = ln_rdata[2'(rd_off_ff + 2'(i))];
      end
   end

   // load data extension
   always_comb begin
      case (ins_ff[14:12])
         F3_B:    load_val = {{24{mem_word[7]}}, mem_word[7:0]};
         F3_H:    load_val = {{16{mem_word[15]}}, mem_word[15:0]};
         F3_BU:   load_val = {24'd0, mem_word[7:0]};
         F3_HU:   load_val = {16'd0, mem_word[15:0]};
         default: load_val = mem_word;
      endcase
   end

   // immediates, ALU, branch and jump targets
   always_comb begin
      ex_op    = ins_ff[6:0];
      ex_f3    = ins_ff[14:12];
      ex_rd    = ins_ff[11:7];
      immi     = {{20{ins_ff[31]}}, ins_ff[31:20]};
      imms     = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
      immb     = {{19{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25],
                  ins_ff[11:8], 1'b0};
      immj     = {{11{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20],
                  ins_ff[30:21], 1'b0};
      immu     = {ins_ff[31:12], 12'd0};
      alu_b    = (ex_op == OP_REG) ? rfb_val : immi;
      alu_alt  = (ex_op == OP_REG) ? ins_ff[30] : (ex_f3 == F3_SR && ins_ff[30]);
      alu_q    = alu(ex_f3, alu_alt, rfa_val, alu_b);
      ld_addr  = rfa_val + immi;
      st_addr  = rfa_val + imms;
      pc_plus4 = pc_ff + 32'd4;
      ex_take  = take_branch(ex_f3, rfa_val, rfb_val);
      case (ex_op)
         OP_JAL:  jmp_tgt = pc_ff + immj;
         OP_JALR: jmp_tgt = ld_addr;
         default: jmp_tgt = pc_ff + immb;
      endcase
      ex_jump = (ex_op == OP_JAL) || (ex_op == OP_JALR) ||
                (ex_op == OP_BRANCH && ex_take);
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      ins_in       = ins_ff;
      rd_off_in    = rd_off_ff;
      clr_in       = clr_ff;
      vld_in       = vld_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      mem_addr     = '0;
      mem_wr       = 1'b0;
      mem_last     = LAST_WORD;
      mem_wdata    = '0;
      rf_raddr_a   = 5'd0;
      rf_raddr_b   = 5'd0;
      rf_we        = 1'b0;
      rf_waddr     = ex_rd;
      rf_wdata     = '0;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + RAW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in = '0;
               case (req_data.kind)
                  KIND_LOAD: begin
                     mem_addr  = AW'(32'(req_data.load_address));
                     mem_wr    = 1'b1;
                     mem_wdata = req_data.load_data;
                     state_in  = ST_DONE;
                  end
                  KIND_QUERY: begin
                     rf_raddr_a = req_data.query_index;
                     state_in   = ST_QUERY;
                  end
                  KIND_STEP: begin
                     res_in.fetch_pc = pc_ff;
                     if (halt_ff) begin
                        res_in.status = STS_HALT;
                        state_in      = ST_DONE;
                     end else begin
                        mem_addr  = pc_ff[AW-1:0];
                        rd_off_in = pc_ff[1:0];
                        state_in  = ST_DECODE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_QUERY: begin
            res_in.query_value = rfa_val;
            state_in           = ST_DONE;
         end

         // instruction word is back; read its source registers
         ST_DECODE: begin
            ins_in              = mem_word;
            res_in.fetched_word = mem_word;
            if (mem_word[6:0] == OP_SYSTEM) begin
               rf_raddr_a = REG_A7;
               rf_raddr_b = REG_A0;
            end else begin
               rf_raddr_a = mem_word[19:15];
               rf_raddr_b = mem_word[24:20];
            end
            state_in = ST_EXEC;
         end

         ST_EXEC: begin
            state_in = ST_DONE;
            pc_in    = pc_plus4;
            case (ex_op)
               OP_REG, OP_IMM, OP_LUI, OP_AUIPC, OP_JAL: begin
                  case (ex_op)
                     OP_LUI:   rf_wdata = immu;
                     OP_AUIPC: rf_wdata = pc_ff + immu;
                     OP_JAL:   rf_wdata = pc_plus4;
                     default:  rf_wdata = alu_q;
                  endcase
               end
               OP_JALR: begin
                  rf_wdata = pc_plus4;
                  if (ex_f3 != F3_PRIV) begin
                     res_in.status = STS_ILLEGAL;
                  end
               end
               OP_BRANCH: begin
                  if (ex_f3 == F3_SLT || ex_f3 == F3_SLTU) begin
                     res_in.status = STS_ILLEGAL;
                  end
               end
               OP_LOAD: begin
                  if (ex_f3 == F3_B || ex_f3 == F3_H || ex_f3 == F3_W ||
                      ex_f3 == F3_BU || ex_f3 == F3_HU) begin
                     mem_addr  = ld_addr[AW-1:0];
                     rd_off_in = ld_addr[1:0];
                     state_in  = ST_LOAD;
                  end else begin
                     res_in.status = STS_ILLEGAL;
                  end
               end
               OP_STORE: begin
                  if (ex_f3 == F3_B || ex_f3 == F3_H || ex_f3 == F3_W) begin
                     mem_addr  = st_addr[AW-1:0];
                     mem_wr    = 1'b1;
                     mem_wdata = rfb_val;
                     mem_last  = (ex_f3 == F3_B) ? LAST_BYTE :
                                 (ex_f3 == F3_H) ? LAST_HALF : LAST_WORD;
                  end else begin
                     res_in.status = STS_ILLEGAL;
                  end
               end
               OP_SYSTEM: begin
                  if (ex_f3 != F3_PRIV) begin
                     res_in.status = STS_ILLEGAL;
                  end else begin
                     res_in.service_number   = rfa_val;
                     res_in.service_argument = rfb_val;
                     res_in.status           = STS_ECALL;
                     if (rfa_val == SVC_EXIT || rfa_val == SVC_EXIT2) begin
                        res_in.status = STS_HALT;
                        halt_in       = 1'b1;
                     end
                  end
               end
               default: res_in.status = STS_ILLEGAL;
            endcase

            if (res_in.status == STS_ILLEGAL) begin
               // illegal: nothing retires, program counter stays
               res_in.service_number   = '0;
               res_in.service_argument = '0;
               halt_in                 = 1'b1;
               pc_in                   = pc_ff;
               mem_wr                  = 1'b0;
               state_in                = ST_DONE;
            end else begin
               if (ex_jump && jmp_tgt != pc_ff) begin
                  pc_in = jmp_tgt;
               end
               if ((ex_op == OP_REG || ex_op == OP_IMM || ex_op == OP_LUI ||
                    ex_op == OP_AUIPC || ex_op == OP_JAL || ex_op == OP_JALR) &&
                   ex_rd != 5'd0) begin
                  rf_we               = 1'b1;
                  vld_in[ex_rd]       = 1'b1;
                  res_in.dest_written = 1'b1;
                  res_in.dest_number  = ex_rd;
                  res_in.dest_value   = rf_wdata;
               end
            end
         end

         // load data is back; write the destination
         ST_LOAD: begin
            rf_wdata = load_val;
            if (ex_rd != 5'd0) begin
               rf_we               = 1'b1;
               vld_in[ex_rd]       = 1'b1;
               res_in.dest_written = 1'b1;
               res_in.dest_number  = ex_rd;
               res_in.dest_value   = load_val;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         clr_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         clr_ff       <= clr_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ins_ff    <= ins_in;
      rd_off_ff <= rd_off_in;
      idx_a_ff  <= rf_raddr_a;
      idx_b_ff  <= rf_raddr_b;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
